// ----- rtl/core/soed_pkg.sv -----
// Package for the serial output expander driver.
// Holds the function codes, default sizes and the controller/datapath
// command and status structs. No dependencies.
`timescale 1ns / 1ps

package soed_pkg;

    localparam int BUFFER_BYTES_DEF = 4;
    localparam int FUNC_W           = 3;
    localparam int OFFSET_W         = 5;
    localparam int VALUE_W          = 8;
    localparam int RDATA_W          = 8;

    localparam logic [7:0] LO_NIB_MASK = 8'h0F;
    localparam logic [7:0] HI_NIB_MASK = 8'hF0;

    typedef enum logic [FUNC_W-1:0] {
        FN_RD_BIT  = 3'd0,
        FN_WR_BIT  = 3'd1,
        FN_RD_NIB  = 3'd2,
        FN_WR_NIB  = 3'd3,
        FN_RD_BYTE = 3'd4,
        FN_WR_BYTE = 3'd5,
        FN_LD_BYTE = 3'd6,
        FN_REFRESH = 3'd7
    } t_func;

    // Controller to datapath
    typedef struct packed {
        logic capture;      // take the accepted item
        logic apply;        // update the buffer if the item writes
        logic emit_single;  // load the one-result answer
        logic prep_shift;   // copy buffer into shift register, load counter
        logic emit_shift;   // load one shift result, advance
        logic emit_latch;   // load the latch result
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic single;       // read, load or bad offset: one result only
        logic cnt_zero;     // last serial bit is being emitted
        logic out_free;     // output register can take a result
    } t_stat;

endpackage

// ----- rtl/core/soed_ctrl.sv -----
// Controller state machine of the serial output expander driver.
// Sequences capture, update, shift and latch. Depends on soed_pkg.
`timescale 1ns / 1ps

module soed_ctrl
    import soed_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EXEC  = 5'b00010,
        S_PREP  = 5'b00100,
        S_SHIFT = 5'b01000,
        S_LATCH = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.single) begin
                    if (i_stat.out_free) begin
                        o_cmd.apply       = 1'b1;
                        o_cmd.emit_single = 1'b1;
                        n_state           = S_IDLE;
                    end
                end else begin
                    o_cmd.apply = 1'b1;
                    n_state     = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep_shift = 1'b1;
                n_state          = S_SHIFT;
            end
            S_SHIFT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_shift = 1'b1;
                    if (i_stat.cnt_zero) begin
                        n_state = S_LATCH;
                    end
                end
            end
            S_LATCH: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_latch = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/soed_dp.sv -----
// Datapath of the serial output expander driver: item registers, shadow
// buffer, shift register, bit counter and output register.
// Depends on soed_pkg; driven by soed_ctrl.
`timescale 1ns / 1ps

module soed_dp
    import soed_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_stat               o_stat,
    input  logic [FUNC_W-1:0]   i_func,
    input  logic [OFFSET_W-1:0] i_offset,
    input  logic [VALUE_W-1:0]  i_value,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [RDATA_W-1:0]  o_read_data,
    output logic                o_serial_bit,
    output logic                o_shift_pulse,
    output logic                o_latch_pulse,
    output logic                o_bad_offset,
    output logic                o_last
);

    localparam int BITS  = 8 * BUFFER_BYTES;
    localparam int NIBS  = 2 * BUFFER_BYTES;
    localparam int CNTW  = $clog2(BITS);
    localparam int IDXW  = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
    localparam int LIMW  = $clog2(BITS + 1);
    localparam int CMPW  = (LIMW > OFFSET_W) ? LIMW : OFFSET_W;

    t_func                r_func;
    logic [OFFSET_W-1:0]  r_offset;
    logic [VALUE_W-1:0]   r_value;
    logic [7:0]           r_buf [BUFFER_BYTES];
    logic [BITS-1:0]      r_shreg;
    logic [CNTW-1:0]      r_cnt;

    logic                 r_ovalid;
    logic [RDATA_W-1:0]   r_rd;
    logic                 r_sb, r_sp, r_lp, r_bad, r_last;

    logic [CMPW-1:0]      off_ext;
    logic                 bad;
    logic                 is_read;
    logic                 is_write;
    logic [OFFSET_W-1:0]  idx_full;
    logic [IDXW-1:0]      idx;
    logic [7:0]           cur_byte;
    logic [7:0]           new_byte;
    logic [RDATA_W-1:0]   rd_val;
    logic [BITS-1:0]      buf_flat;
    logic                 out_free;

    assign off_ext = CMPW'(r_offset);

    always_comb begin
        bad      = 1'b0;
        is_read  = 1'b0;
        is_write = 1'b0;
        idx_full = r_offset;
        case (r_func)
            FN_RD_BIT, FN_WR_BIT: begin
                bad      = (off_ext >= CMPW'(BITS));
                idx_full = r_offset >> 3;
                is_read  = (r_func == FN_RD_BIT);
                is_write = (r_func == FN_WR_BIT);
            end
            FN_RD_NIB, FN_WR_NIB: begin
                bad      = (off_ext >= CMPW'(NIBS));
                idx_full = r_offset >> 1;
                is_read  = (r_func == FN_RD_NIB);
                is_write = (r_func == FN_WR_NIB);
            end
            FN_RD_BYTE, FN_WR_BYTE, FN_LD_BYTE: begin
                bad      = (off_ext >= CMPW'(BUFFER_BYTES));
                is_read  = (r_func == FN_RD_BYTE);
                is_write = (r_func != FN_RD_BYTE);
            end
            default: begin
                // refresh: offset and value ignored
            end
        endcase
    end

    assign idx      = IDXW'(idx_full);
    assign cur_byte = r_buf[idx];

    always_comb begin
        new_byte = cur_byte;
        rd_val   = '0;
        case (r_func)
            FN_RD_BIT: begin
                rd_val = RDATA_W'(cur_byte[r_offset[2:0]]);
            end
            FN_WR_BIT: begin
                new_byte[r_offset[2:0]] = r_value[0];
            end
            FN_RD_NIB: begin
                rd_val = r_offset[0] ? (cur_byte >> 4) : (cur_byte & LO_NIB_MASK);
            end
            FN_WR_NIB: begin
                if (r_offset[0]) begin
                    new_byte = (cur_byte & LO_NIB_MASK) | {r_value[3:0], 4'h0};
                end else begin
                    new_byte = (cur_byte & HI_NIB_MASK) | {4'h0, r_value[3:0]};
                end
            end
            FN_RD_BYTE: begin
                rd_val = cur_byte;
            end
            FN_WR_BYTE, FN_LD_BYTE: begin
                new_byte = r_value;
            end
            default: begin
                new_byte = cur_byte;
            end
        endcase
    end

    always_comb begin
        for (int i = 0; i < BUFFER_BYTES; i++) begin
            buf_flat[8*i +: 8] = r_buf[i];
        end
    end

    assign out_free = !r_ovalid || i_out_ready;

    assign o_stat.single   = bad || is_read || (r_func == FN_LD_BYTE);
    assign o_stat.cnt_zero = (r_cnt == '0);
    assign o_stat.out_free = out_free;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func   <= t_func'(i_func);
            r_offset <= i_offset;
            r_value  <= i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < BUFFER_BYTES; i++) begin
                r_buf[i] <= '0;
            end
        end else if (i_cmd.apply && is_write && !bad) begin
            r_buf[idx] <= new_byte;
        end
    end

    // Highest byte, MSB first: shift left and send the top bit
    always_ff @(posedge i_clk) begin
        if (i_cmd.prep_shift) begin
            r_shreg <= buf_flat;
            r_cnt   <= CNTW'(BITS - 1);
        end else if (i_cmd.emit_shift) begin
            r_shreg <= r_shreg << 1;
            r_cnt   <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit_single || i_cmd.emit_shift || i_cmd.emit_latch) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_single) begin
            r_rd   <= bad ? '0 : rd_val;
            r_sb   <= 1'b0;
            r_sp   <= 1'b0;
            r_lp   <= 1'b0;
            r_bad  <= bad;
            r_last <= 1'b1;
        end else if (i_cmd.emit_shift) begin
            r_rd   <= '0;
            r_sb   <= r_shreg[BITS-1];
            r_sp   <= 1'b1;
            r_lp   <= 1'b0;
            r_bad  <= 1'b0;
            r_last <= 1'b0;
        end else if (i_cmd.emit_latch) begin
            r_rd   <= '0;
            r_sb   <= 1'b0;
            r_sp   <= 1'b0;
            r_lp   <= 1'b1;
            r_bad  <= 1'b0;
            r_last <= 1'b1;
        end
    end

    assign o_out_valid   = r_ovalid;
    assign o_read_data   = r_rd;
    assign o_serial_bit  = r_sb;
    assign o_shift_pulse = r_sp;
    assign o_latch_pulse = r_lp;
    assign o_bad_offset  = r_bad;
    assign o_last        = r_last;

endmodule

// ----- rtl/core/serial_output_expander_driver.sv -----
// Serial output expander driver: keeps a BUFFER_BYTES shadow buffer for a
// chain of serial-in parallel-out registers and answers read, write, load
// and refresh items with a stream of result items. One item is taken at a
// time. A read, load or bad-offset item gives its single result; a write or
// refresh takes an update step and a set-up step, then 8*BUFFER_BYTES
// shift results and one latch result (tlast), one a cycle while the output
// side is ready. The synchronous reset clears the buffer to zeros.
// Depends on soed_pkg, soed_ctrl and soed_dp.
`timescale 1ns / 1ps

module serial_output_expander_driver
    import soed_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,  // func[2:0], offset[7:3], value[15:8]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // read_data[7:0], serial_bit[8], shift_pulse[9], latch_pulse[10],
    // bad_offset[11], zero[15:12]
    output logic [15:0] o_m_axis_tdata,
    output logic        o_m_axis_tlast
);

    t_cmd  cmd;
    t_stat stat;

    logic [RDATA_W-1:0] read_data;
    logic               serial_bit, shift_pulse, latch_pulse, bad_offset;

    soed_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    soed_dp #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_func        (i_s_axis_tdata[2:0]),
        .i_offset      (i_s_axis_tdata[7:3]),
        .i_value       (i_s_axis_tdata[15:8]),
        .i_out_ready   (i_m_axis_tready),
        .o_out_valid   (o_m_axis_tvalid),
        .o_read_data   (read_data),
        .o_serial_bit  (serial_bit),
        .o_shift_pulse (shift_pulse),
        .o_latch_pulse (latch_pulse),
        .o_bad_offset  (bad_offset),
        .o_last        (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {4'h0, bad_offset, latch_pulse, shift_pulse, serial_bit,
                             read_data};

endmodule

// ----- rtl/core/soed_chk.sv -----
// Port-level checker for the serial output expander driver, bound to the
// top level. Depends on the top level's port list only.
`timescale 1ns / 1ps

module soed_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [15:0] i_s_axis_tdata,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [15:0] o_m_axis_tdata,
    input logic        o_m_axis_tlast
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("result changed while stalled");

    // One item at a time: no accept in the cycle after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input ready right after an accept");

    a_latch_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[10] |->
            o_m_axis_tlast && !o_m_axis_tdata[9] && (o_m_axis_tdata[7:0] == 8'h00))
        else $error("latch result malformed");

    a_shift_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[9] |->
            !o_m_axis_tlast && (o_m_axis_tdata[7:0] == 8'h00) && !o_m_axis_tdata[11])
        else $error("shift result malformed");

    a_bad_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[11] |->
            o_m_axis_tlast && (o_m_axis_tdata[10:0] == 11'h000))
        else $error("bad offset result malformed");

endmodule

bind serial_output_expander_driver soed_chk u_soed_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

// ----- test/serial_output_expander_driver_tb.sv -----
// Testbench for serial_output_expander_driver: drives read, write, load and refresh items,
// predicts every shift, latch and read result from its own shadow buffer and checks them.
// Depends on soed_pkg and the serial_output_expander_driver RTL.
`timescale 1ns / 1ps

module serial_output_expander_driver_tb;
    import soed_pkg::*;

    localparam int NB          = BUFFER_BYTES_DEF;
    localparam int HALF_PERIOD = 6;
    localparam int STALL_LIMIT = 4000;
    localparam int SETTLE      = 12;
    localparam int MAX_REPORTS = 40;

    typedef struct {
        logic [7:0] rd;
        logic       sb;
        logic       sp;
        logic       lp;
        logic       bad;
        logic       lst;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [15:0] i_s_axis_tdata = '0;  // func[2:0], offset[7:3], value[15:8]
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    // read_data[7:0], serial_bit[8], shift_pulse[9], latch_pulse[10],
    // bad_offset[11], zero[15:12]
    logic [15:0] o_m_axis_tdata;
    logic        o_m_axis_tlast;

    logic [7:0] shadow_bytes [NB];
    t_result    pending_results [$];

    int err_cnt = 0;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int hold_len = 0;
    int quiet_cycles = 0;
    int items_sent = 0;
    int writes_sent = 0;
    int bad_sent = 0;
    int results_seen = 0;

    serial_output_expander_driver #(.BUFFER_BYTES(NB)) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        if (err_cnt < MAX_REPORTS) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        err_cnt++;
    endtask

    function automatic int offset_limit(input t_func fn);
        if (fn == FN_RD_BIT || fn == FN_WR_BIT) begin
            return 8 * NB;
        end else if (fn == FN_RD_NIB || fn == FN_WR_NIB) begin
            return 2 * NB;
        end
        return NB;
    endfunction

    task automatic push_result(input logic [7:0] rd, input logic sb, input logic sp,
                               input logic lp, input logic bad, input logic lst);
        t_result r;
        r.rd  = rd;
        r.sb  = sb;
        r.sp  = sp;
        r.lp  = lp;
        r.bad = bad;
        r.lst = lst;
        pending_results.push_back(r);
    endtask

    // Whole buffer, highest byte first, MSB first, then the latch.
    task automatic push_shift_out();
        for (int i = NB - 1; i >= 0; i--) begin
            for (int j = 7; j >= 0; j--) begin
                push_result(8'h00, shadow_bytes[i][j], 1'b1, 1'b0, 1'b0, 1'b0);
            end
        end
        push_result(8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1);
    endtask

    task automatic predict_item(input t_func fn, input logic [4:0] off,
                                input logic [7:0] val);
        int idx;
        if (fn != FN_REFRESH && int'(off) >= offset_limit(fn)) begin
            bad_sent++;
            push_result(8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
            return;
        end
        case (fn)
            FN_RD_BIT: begin
                idx = off >> 3;
                push_result({7'd0, shadow_bytes[idx][off[2:0]]}, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
            end
            FN_WR_BIT: begin
                idx = off >> 3;
                shadow_bytes[idx][off[2:0]] = val[0];
                push_shift_out();
            end
            FN_RD_NIB: begin
                idx = off >> 1;
                push_result(off[0] ? {4'd0, shadow_bytes[idx][7:4]}
                                   : {4'd0, shadow_bytes[idx][3:0]},
                            1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
            end
            FN_WR_NIB: begin
                idx = off >> 1;
                if (off[0]) begin
                    shadow_bytes[idx][7:4] = val[3:0];
                end else begin
                    shadow_bytes[idx][3:0] = val[3:0];
                end
                push_shift_out();
            end
            FN_RD_BYTE: begin
                push_result(shadow_bytes[off], 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
            end
            FN_WR_BYTE: begin
                shadow_bytes[off] = val;
                push_shift_out();
            end
            FN_LD_BYTE: begin
                shadow_bytes[off] = val;
                push_result(8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
            end
            default: begin
                push_shift_out();
            end
        endcase
        if (fn == FN_WR_BIT || fn == FN_WR_NIB || fn == FN_WR_BYTE || fn == FN_REFRESH) begin
            writes_sent++;
        end
    endtask

    // Offer one item; hold it until taken, then predict its results.
    task automatic send_item(input t_func fn, input logic [4:0] off, input logic [7:0] val);
        int gap;
        gap = 0;
        if ($urandom_range(99) < tx_idle_pct) begin
            gap = ($urandom_range(7) == 0) ? $urandom_range(4, 40) : $urandom_range(1, 3);
        end
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {val, off, fn};
        do @(posedge i_clk); while (!o_s_axis_tready);
        items_sent++;
        predict_item(fn, off, val);
    endtask

    task automatic send_random_item();
        t_func      fn;
        logic [4:0] off;
        int         lim;
        fn  = t_func'($urandom_range(7));
        lim = offset_limit(fn);
        if (lim < 32 && $urandom_range(99) < 12) begin
            off = 5'($urandom_range(31, lim));
        end else begin
            off = 5'($urandom_range(lim - 1));
        end
        if (fn == FN_REFRESH) begin
            off = 5'($urandom_range(31));
        end
        send_item(fn, off, 8'($urandom_range(255)));
    endtask

    // Stop offering and wait for every outstanding result.
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_idling(input int tx_pct, input int rx_pct);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
    endtask

    task automatic test_directed();
        send_item(FN_RD_BIT, 5'd0, 8'hFF);
        send_item(FN_RD_BYTE, 5'd3, 8'h00);
        send_item(FN_WR_BIT, 5'd0, 8'h01);
        send_item(FN_WR_BIT, 5'd31, 8'hFF);
        send_item(FN_RD_BIT, 5'd31, 8'h00);
        // bit write takes bit 0 only
        send_item(FN_WR_BIT, 5'd31, 8'hFE);
        send_item(FN_RD_BIT, 5'd31, 8'h00);
        // nibble write ignores the upper half of value
        send_item(FN_WR_NIB, 5'd7, 8'hAB);
        send_item(FN_WR_NIB, 5'd0, 8'h5C);
        send_item(FN_RD_NIB, 5'd7, 8'h00);
        send_item(FN_RD_NIB, 5'd0, 8'h00);
        send_item(FN_WR_BYTE, 5'd3, 8'hFF);
        send_item(FN_WR_BYTE, 5'd0, 8'h00);
        send_item(FN_LD_BYTE, 5'd1, 8'h5A);
        send_item(FN_RD_BYTE, 5'd1, 8'h00);
        send_item(FN_REFRESH, 5'd31, 8'hFF);
        // out of range: nothing changes and nothing is shifted
        send_item(FN_RD_NIB, 5'd8, 8'h00);
        send_item(FN_WR_NIB, 5'd31, 8'hFF);
        send_item(FN_RD_BYTE, 5'd4, 8'h00);
        send_item(FN_WR_BYTE, 5'd31, 8'hFF);
        send_item(FN_LD_BYTE, 5'd16, 8'hFF);
        send_item(FN_RD_BYTE, 5'd3, 8'h00);
        send_item(FN_REFRESH, 5'd0, 8'h00);
        drain();
    endtask

    task automatic test_random(input int count);
        for (int n = 0; n < count; n++) begin
            send_random_item();
        end
        drain();
    endtask

    // Receiver held off while items keep arriving: output fills, input stalls.
    task automatic test_backpressure();
        hold_len = 400;
        send_item(FN_WR_BYTE, 5'd2, 8'hC3);
        send_item(FN_WR_NIB, 5'd1, 8'h09);
        send_item(FN_RD_BYTE, 5'd0, 8'h00);
        send_item(FN_REFRESH, 5'd5, 8'h11);
        drain();
    endtask

    // Receiver side: long hold-off when asked, random stalls otherwise.
    always @(posedge i_clk) begin
        if (hold_len > 0) begin
            i_m_axis_tready <= 1'b0;
            hold_len = hold_len - 1;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result tdata=%h tlast=%b",
                                          o_m_axis_tdata, o_m_axis_tlast));
            end else begin
                want = pending_results.pop_front();
                if (o_m_axis_tdata[7:0] !== want.rd) begin
                    report_mismatch($sformatf("read_data %h, want %h",
                                              o_m_axis_tdata[7:0], want.rd));
                end
                if (o_m_axis_tdata[8] !== want.sb) begin
                    report_mismatch($sformatf("serial_bit %b, want %b",
                                              o_m_axis_tdata[8], want.sb));
                end
                if (o_m_axis_tdata[9] !== want.sp) begin
                    report_mismatch($sformatf("shift_pulse %b, want %b",
                                              o_m_axis_tdata[9], want.sp));
                end
                if (o_m_axis_tdata[10] !== want.lp) begin
                    report_mismatch($sformatf("latch_pulse %b, want %b",
                                              o_m_axis_tdata[10], want.lp));
                end
                if (o_m_axis_tdata[11] !== want.bad) begin
                    report_mismatch($sformatf("bad_offset %b, want %b",
                                              o_m_axis_tdata[11], want.bad));
                end
                if (o_m_axis_tdata[15:12] !== 4'd0) begin
                    report_mismatch($sformatf("padding bits %h, want 0",
                                              o_m_axis_tdata[15:12]));
                end
                if (o_m_axis_tlast !== want.lst) begin
                    report_mismatch($sformatf("tlast %b, want %b", o_m_axis_tlast, want.lst));
                end
            end
        end
    end

    // Watchdog: end the run if no item moves on either side for too long.
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
            $display("serial_output_expander_driver test failed");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < NB; i++) begin
            shadow_bytes[i] = 8'h00;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_idling(0, 0);
        test_directed();
        test_backpressure();
        test_random(114);
        set_idling(67, 0);
        test_random(114);
        set_idling(0, 67);
        test_random(114);
        set_idling(30, 30);
        test_random(114);

        repeat (SETTLE) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        end
        $display("covered %0d items (%0d shifting, %0d out of range), %0d results checked",
                 items_sent, writes_sent, bad_sent, results_seen);
        $display("idling phases: none, sender, receiver, both; one long receiver hold-off");
        if (err_cnt == 0) begin
            $display("serial_output_expander_driver test passed");
        end else begin
            $display("serial_output_expander_driver test failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/soed_pkg.sv
rtl/core/soed_ctrl.sv
rtl/core/soed_dp.sv
rtl/core/serial_output_expander_driver.sv
rtl/core/soed_chk.sv
test/serial_output_expander_driver_tb.sv
